[hw/rtl/least_loaded_worker_dispatcher_unit_assert.svh]
// ----------------------------------------------------------------------------
// least loaded dispatcher assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_WORKER_DISPATCHER_UNIT_ASSERT_SVH
`define LEAST_LOADED_WORKER_DISPATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define LLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// next-cycle implication
`define LLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

[hw/rtl/lld_pkg.sv]
// ----------------------------------------------------------------------------
// lld_pkg
// shared types, codes and defaults of the least loaded worker dispatcher
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int WORKER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS_DEF  = 64;

  localparam logic [7:0]  CONCURRENCY_RST = 8'd10;
  localparam logic [4:0]  POOL_CAP_RST    = 5'd10;
  localparam logic [9:0]  GROW_STEP_RST   = 10'd8;
  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd60;

  typedef enum logic [2:0] {
    OP_REQUEST = 3'd0,
    OP_FINISH  = 3'd1,
    OP_READY   = 3'd2,
    OP_DIED    = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ACT_ASSIGN  = 2'd0,
    ACT_SPAWN   = 2'd1,
    ACT_DESPAWN = 2'd2,
    ACT_QUEUED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_CONCURRENCY = 2'd0,
    REG_POOL_CAP    = 2'd1,
    REG_GROW_STEP   = 2'd2,
    REG_IDLE_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN_CLR,
    CMD_SCAN_STEP,
    CMD_ASSIGN,
    CMD_ASSIGN_Q,
    CMD_SPAWN,
    CMD_ENQ,
    CMD_DIV_START,
    CMD_DESP_STEP,
    CMD_FLUSH
  } lld_cmd_t;

  typedef struct packed {
    logic pool_empty;
    logic pend_zero;
    logic best_found;
    logic scan_last;
    logic res_full;
    logic emit_ready;
    logic out_free;
    logic held_valid;
    logic bal_skip;
    logic div_done;
    logic need_spawn;
    logic free_found;
    logic desp_hit;
  } lld_stat_t;

endpackage

[hw/rtl/lld_in_if.sv]
// ----------------------------------------------------------------------------
// lld_in_if
// event channel into the dispatcher
// ----------------------------------------------------------------------------
interface lld_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [3:0] worker;

  modport source (output valid, op, worker, input ready);
  modport sink (input valid, op, worker, output ready);
endinterface

[hw/rtl/lld_out_if.sv]
// ----------------------------------------------------------------------------
// lld_out_if
// result channel out of the dispatcher
// ----------------------------------------------------------------------------
interface lld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] slot;
  logic       last;

  modport source (output valid, action, slot, last, input ready);
  modport sink (input valid, action, slot, last, output ready);
endinterface

[hw/rtl/lld_div.sv]
// ----------------------------------------------------------------------------
// lld_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lld_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [9:0]  divisor,
  output logic [15:0] quotient,
  output logic        busy
);

  logic [4:0]  count;
  logic [9:0]  rem;
  logic [9:0]  dsr;
  logic [10:0] shifted;
  logic [10:0] diff;
  logic        ge;

  // trial subtract
  assign shifted = {rem, quotient[15]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 5'd16;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[9:0] : shifted[9:0];
      quotient <= {quotient[14:0], ge};
      count    <= count - 5'd1;
      if (count == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lld_dp.sv]
// ----------------------------------------------------------------------------
// lld_dp
// slot table, pending count, scan unit, divider and result stage
// ----------------------------------------------------------------------------
module lld_dp import lld_pkg::*; #(
  parameter int SLOTS = WORKER_SLOTS_DEF,
  parameter int MAXR  = MAX_RESULTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_worker,
  input  lld_cmd_t    cmd,
  output lld_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [3:0]  out_slot,
  output logic        out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = $clog2(MAXR + 1);

  // configuration
  logic [7:0]  concurrency;
  logic [4:0]  pool_cap;
  logic [9:0]  grow_step;
  logic [15:0] idle_limit;

  // slot table
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] active;
  logic [7:0]       load [SLOTS];
  logic [15:0]      idle [SLOTS];
  logic [15:0]      pending;
  logic [CW-1:0]    used_cnt;

  // scan and result state
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] best_idx;
  logic [7:0]    best_load;
  logic          best_valid;
  logic [RW-1:0] res_n;
  logic          held_valid;
  logic [1:0]    held_action;
  logic [3:0]    held_slot;

  // combinational helpers
  logic [7:0]    wk_ext;
  logic          wk_ok;
  logic [IW-1:0] wk_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          res_full;
  logic          out_free;
  logic          emit_ready;
  logic [6:0]    lim;
  logic [9:0]    thr;
  logic [16:0]   prod;
  logic [15:0]   quotient;
  logic          div_busy;
  logic [15:0]   target;
  logic          pick_hit;
  logic          desp_hit;
  logic          emit_do;
  logic [1:0]    emit_act;
  logic [3:0]    emit_slot;

  assign wk_ext = {4'd0, in_worker};
  assign wk_ok  = wk_ext < 8'(SLOTS);
  assign wk_idx = wk_ext[IW-1:0];

  // lowest unused slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign res_full   = res_n >= RW'(MAXR);
  assign out_free   = !out_valid || out_ready;
  assign emit_ready = !held_valid || out_free;

  // pool growth target
  assign lim  = (7'(pool_cap) < 7'(SLOTS)) ? 7'(pool_cap) : 7'(SLOTS);
  assign thr  = (grow_step == 10'd0) ? 10'd1 : grow_step;
  assign prod = 17'(used_cnt) * 17'(thr);

  always_comb begin
    target = (quotient > 16'(lim)) ? 16'(lim) : quotient;
    if (target == 16'd0) begin
      target = 16'd1;
    end
  end

  lld_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd == CMD_DIV_START),
    .dividend (pending),
    .divisor  (thr),
    .quotient (quotient),
    .busy     (div_busy)
  );

  // per-slot tests at the scan pointer
  assign pick_hit = used[scan_idx] && active[scan_idx] && (load[scan_idx] < concurrency) &&
                    (!best_valid || load[scan_idx] < best_load);
  assign desp_hit = used[scan_idx] && active[scan_idx] && (load[scan_idx] == 8'd0) &&
                    (idle[scan_idx] > idle_limit);

  // status to the controller
  always_comb begin
    stat.pool_empty = used_cnt == '0;
    stat.pend_zero  = pending == 16'd0;
    stat.best_found = best_valid;
    stat.scan_last  = scan_idx == IW'(SLOTS - 1);
    stat.res_full   = res_full;
    stat.emit_ready = emit_ready;
    stat.out_free   = out_free;
    stat.held_valid = held_valid;
    stat.bal_skip   = (7'(used_cnt) >= lim) || (prod >= 17'(pending));
    stat.div_done   = !div_busy;
    stat.need_spawn = 16'(used_cnt) < target;
    stat.free_found = free_found;
    stat.desp_hit   = desp_hit;
  end

  // result produced this cycle
  always_comb begin
    emit_do   = 1'b0;
    emit_act  = ACT_ASSIGN;
    emit_slot = 4'd0;
    case (cmd)
      CMD_ASSIGN, CMD_ASSIGN_Q: begin
        emit_do   = !res_full;
        emit_slot = 4'(best_idx);
      end
      CMD_SPAWN: begin
        emit_do   = !res_full && free_found;
        emit_act  = ACT_SPAWN;
        emit_slot = 4'(free_idx);
      end
      CMD_ENQ: begin
        emit_do  = !res_full;
        emit_act = ACT_QUEUED;
      end
      CMD_DESP_STEP: begin
        emit_do   = desp_hit && !res_full;
        emit_act  = ACT_DESPAWN;
        emit_slot = 4'(scan_idx);
      end
      default: begin
        emit_do = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      concurrency <= CONCURRENCY_RST;
      pool_cap    <= POOL_CAP_RST;
      grow_step   <= GROW_STEP_RST;
      idle_limit  <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONCURRENCY: concurrency <= cfg_data[7:0];
        REG_POOL_CAP:    pool_cap <= cfg_data[4:0];
        REG_GROW_STEP:   grow_step <= cfg_data[9:0];
        REG_IDLE_LIMIT:  idle_limit <= cfg_data;
        default:         concurrency <= concurrency;
      endcase
    end
  end

  // slot table and pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      active   <= '0;
      used_cnt <= '0;
      pending  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        load[i] <= '0;
        idle[i] <= '0;
      end
    end else begin
      case (cmd)
        CMD_LOAD: begin
          case (in_op)
            OP_FINISH: begin
              if (wk_ok && used[wk_idx]) begin
                if (load[wk_idx] != 8'd0) begin
                  load[wk_idx] <= load[wk_idx] - 8'd1;
                end
                idle[wk_idx] <= '0;
              end
            end
            OP_READY: begin
              if (wk_ok && used[wk_idx]) begin
                active[wk_idx] <= 1'b1;
                idle[wk_idx]   <= '0;
              end
            end
            OP_DIED: begin
              if (wk_ok) begin
                if (used[wk_idx]) begin
                  used_cnt <= used_cnt - CW'(1);
                end
                used[wk_idx]   <= 1'b0;
                active[wk_idx] <= 1'b0;
                load[wk_idx]   <= '0;
                idle[wk_idx]   <= '0;
              end
            end
            OP_TICK: begin
              for (int i = 0; i < SLOTS; i++) begin
                if (used[i] && active[i] && idle[i] != 16'hFFFF) begin
                  idle[i] <= idle[i] + 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_ASSIGN, CMD_ASSIGN_Q: begin
          if (!res_full) begin
            if (load[best_idx] != 8'hFF) begin
              load[best_idx] <= load[best_idx] + 8'd1;
            end
            idle[best_idx] <= '0;
            if (cmd == CMD_ASSIGN_Q) begin
              pending <= pending - 16'd1;
            end
          end
        end
        CMD_SPAWN: begin
          if (emit_do) begin
            used[free_idx]   <= 1'b1;
            active[free_idx] <= 1'b0;
            load[free_idx]   <= '0;
            idle[free_idx]   <= '0;
            used_cnt         <= used_cnt + CW'(1);
          end
        end
        CMD_ENQ: begin
          if (pending != 16'hFFFF) begin
            pending <= pending + 16'd1;
          end
        end
        CMD_DESP_STEP: begin
          if (emit_do) begin
            used[scan_idx]   <= 1'b0;
            active[scan_idx] <= 1'b0;
            load[scan_idx]   <= '0;
            idle[scan_idx]   <= '0;
            used_cnt         <= used_cnt - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // scan pointer and best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD, CMD_SCAN_CLR: begin
          scan_idx   <= '0;
          best_valid <= 1'b0;
        end
        CMD_SCAN_STEP, CMD_DESP_STEP: begin
          if (cmd == CMD_SCAN_STEP && pick_hit) begin
            best_valid <= 1'b1;
            best_idx   <= scan_idx;
            best_load  <= load[scan_idx];
          end
          scan_idx <= stat.scan_last ? '0 : scan_idx + IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_n      <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd == CMD_LOAD) begin
        res_n <= '0;
      end
      // held result moves out on a newer result or at the end of the event
      if (cmd == CMD_FLUSH || (emit_do && held_valid)) begin
        out_valid  <= 1'b1;
        out_action <= held_action;
        out_slot   <= held_slot;
        out_last   <= (cmd == CMD_FLUSH);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit_do) begin
        held_valid  <= 1'b1;
        held_action <= emit_act;
        held_slot   <= emit_slot;
        res_n       <= res_n + RW'(1);
      end
      if (cmd == CMD_FLUSH) begin
        held_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lld_ctrl.sv]
// ----------------------------------------------------------------------------
// lld_ctrl
// sequencer that steps the datapath through each event
// ----------------------------------------------------------------------------
module lld_ctrl import lld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [2:0] in_op,
  output logic      in_ready,
  input  lld_stat_t stat,
  output lld_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSPAWN,
    S_RSCAN,
    S_RPICK,
    S_ENQ,
    S_DRAIN,
    S_DSCAN,
    S_DPICK,
    S_BAL,
    S_DIV,
    S_GROW,
    S_TICK,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   bal;
  logic   bal_next;
  state_t after_drain;

  assign in_ready    = state == S_IDLE;
  assign after_drain = bal ? S_BAL : S_FIN;

  // next state and command
  always_comb begin
    state_next = state;
    bal_next   = bal;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd      = CMD_LOAD;
          bal_next = 1'b0;
          case (in_op)
            OP_REQUEST: state_next = stat.pool_empty ? S_RSPAWN : S_RSCAN;
            OP_FINISH:  state_next = S_DRAIN;
            OP_READY:   state_next = S_DRAIN;
            OP_DIED:    state_next = S_BAL;
            OP_TICK:    state_next = S_TICK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_RSPAWN: begin
        if (stat.emit_ready) begin
          cmd        = CMD_SPAWN;
          bal_next   = 1'b1;
          state_next = S_ENQ;
        end
      end
      S_RSCAN: begin
        cmd = CMD_SCAN_STEP;
        if (stat.scan_last) begin
          state_next = S_RPICK;
        end
      end
      S_RPICK: begin
        if (!stat.best_found) begin
          bal_next   = 1'b1;
          state_next = S_ENQ;
        end else if (stat.emit_ready) begin
          cmd        = CMD_ASSIGN;
          state_next = S_FIN;
        end
      end
      S_ENQ: begin
        if (stat.emit_ready) begin
          cmd        = CMD_ENQ;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pool_empty || stat.pend_zero) begin
          state_next = after_drain;
        end else begin
          cmd        = CMD_SCAN_CLR;
          state_next = S_DSCAN;
        end
      end
      S_DSCAN: begin
        cmd = CMD_SCAN_STEP;
        if (stat.scan_last) begin
          state_next = S_DPICK;
        end
      end
      S_DPICK: begin
        if (!stat.best_found || stat.res_full) begin
          state_next = after_drain;
        end else if (stat.emit_ready) begin
          cmd        = CMD_ASSIGN_Q;
          state_next = S_DRAIN;
        end
      end
      S_BAL: begin
        if (stat.bal_skip) begin
          state_next = S_FIN;
        end else begin
          cmd        = CMD_DIV_START;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_GROW;
        end
      end
      S_GROW: begin
        if (!stat.need_spawn || !stat.free_found || stat.res_full) begin
          state_next = S_FIN;
        end else if (stat.emit_ready) begin
          cmd = CMD_SPAWN;
        end
      end
      S_TICK: begin
        if (stat.desp_hit && stat.res_full) begin
          state_next = S_FIN;
        end else if (!stat.desp_hit || stat.emit_ready) begin
          cmd = CMD_DESP_STEP;
          if (stat.scan_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!stat.held_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd        = CMD_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bal   <= 1'b0;
    end else begin
      state <= state_next;
      bal   <= bal_next;
    end
  end

endmodule

[hw/rtl/least_loaded_worker_dispatcher_unit.sv]
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatcher_unit
// assigns requests to the least loaded worker and scales the worker pool
// ----------------------------------------------------------------------------
// Events enter on the in channel (op, worker); each one yields zero or more
// results on the out channel (action, slot, last), last marking the final
// result of the event. Registers are written on cfg_we with cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. One event is handled at a time. A slot
// scan visits the slots one by one, so a request to a free worker scans the
// table before the assignment, each queued request drained adds another
// scan, a pool growth adds the check, the divider and the final test plus a
// spawn step for each new worker, and a tick scans the table for despawns.
// Results leave through a one-deep holding stage and an output register;
// when the receiver stalls the sequencer waits at its next result and no
// result is dropped.
// Synchronous reset empties the slot table, clears the pending count, loads
// the default register values and drops any undelivered result.
// ----------------------------------------------------------------------------
module least_loaded_worker_dispatcher_unit import lld_pkg::*; #(
  parameter int WORKER_SLOTS = WORKER_SLOTS_DEF,
  parameter int MAX_RESULTS  = MAX_RESULTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lld_in_if.sink      in,
  lld_out_if.source   out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "least_loaded_worker_dispatcher_unit_assert.svh"

  lld_cmd_t  cmd;
  lld_stat_t stat;
  logic      emit_cmd;

  // sequencer
  lld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_op    (in.op),
    .in_ready (in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  lld_dp #(
    .SLOTS (WORKER_SLOTS),
    .MAXR  (MAX_RESULTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (in.op),
    .in_worker  (in.worker),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .out_action (out.action),
    .out_slot   (out.slot),
    .out_last   (out.last)
  );

  // commands that produce a result unless the result limit is reached or no slot is free to spawn
  assign emit_cmd = (cmd == CMD_ASSIGN) || (cmd == CMD_ASSIGN_Q) ||
                    (cmd == CMD_SPAWN) || (cmd == CMD_ENQ);

  // no result is left behind when a new request can be taken
  `LLD_ASSERT_NOW(a_idle_flushed, in.ready, !stat.held_valid)

  // results are only produced when the holding stage can move
  `LLD_ASSERT_NOW(a_emit_room, emit_cmd, stat.emit_ready)

  // unknown ops return straight to idle
  `LLD_ASSERT_NEXT(a_unknown_op, (in.valid && in.ready && in.op[2] && (in.op[1] || in.op[0])), in.ready)

endmodule

[tb/sv/lld_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lld testbench channels
// note: the block's own in/out interfaces are used directly by the testbench
// ----------------------------------------------------------------------------
// the dispatcher's channel interfaces lld_in_if and lld_out_if come with the
// rtl; this file only provides a small bundle for the register write port
interface lld_cfg_if;
  logic        we;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output we, index, data);
  modport sink (input we, index, data);
endinterface

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least loaded worker dispatcher testbench
// drives events with random gaps and stalls, predicts each result sequence
// from a behavioral copy of the slot table and checks every result in order
// ----------------------------------------------------------------------------
module testbench import lld_pkg::*; ();

  localparam int SLOTS = 16;
  localparam int RES_CAP = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] slot;
    logic       last;
  } disp_res_t;

  typedef struct {
    logic [2:0] op;
    logic [3:0] worker;
    int         n_exp;      // -1 when only predicted
    disp_res_t  first_exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lld_in_if  ev_ch ();
  lld_out_if res_ch ();
  lld_cfg_if cfg_ch ();

  least_loaded_worker_dispatcher_unit dut (
    .clk(clk), .rst(rst), .in(ev_ch.sink), .out(res_ch.source),
    .cfg_we(cfg_ch.we), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [7:0]  m_conc;
  logic [4:0]  m_plim;
  logic [9:0]  m_gthr;
  logic [15:0] m_ilim;
  logic        m_used [SLOTS];
  logic        m_act [SLOTS];
  logic [7:0]  m_load [SLOTS];
  logic [15:0] m_idle [SLOTS];
  logic [15:0] m_pend;
  disp_res_t   step_res [$];
  disp_res_t   expected_results [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic bit put_res(input action_t a, input int s);
    disp_res_t r;
    if (step_res.size() >= RES_CAP) return 0;
    r.action = a;
    r.slot = s[3:0];
    r.last = 1'b0;
    step_res.push_back(r);
    return 1;
  endfunction

  function automatic void wipe_slot(input int i);
    m_used[i] = 0; m_act[i] = 0; m_load[i] = '0; m_idle[i] = '0;
  endfunction

  function automatic int used_count();
    int n = 0;
    for (int i = 0; i < SLOTS; i++) n += m_used[i];
    return n;
  endfunction

  function automatic int least_loaded();
    int best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (m_used[i] && m_act[i] && m_load[i] < m_conc)
        if (best < 0 || m_load[i] < m_load[best]) best = i;
    return best;
  endfunction

  function automatic bit give_to(input int i);
    if (!put_res(ACT_ASSIGN, i)) return 0;
    if (m_load[i] < 8'd255) m_load[i]++;
    m_idle[i] = '0;
    return 1;
  endfunction

  function automatic bit spawn_lowest();
    for (int i = 0; i < SLOTS; i++)
      if (!m_used[i]) begin
        if (!put_res(ACT_SPAWN, i)) return 0;
        wipe_slot(i);
        m_used[i] = 1;
        return 1;
      end
    return 0;
  endfunction

  function automatic void drain_pending();
    int w;
    if (used_count() == 0) return;
    while (m_pend > 0) begin
      w = least_loaded();
      if (w < 0) return;
      if (!give_to(w)) return;
      m_pend--;
    end
  endfunction

  function automatic void grow_pool();
    int lim, thr, sz, tgt;
    lim = (m_plim < SLOTS) ? m_plim : SLOTS;
    thr = (m_gthr != 0) ? m_gthr : 1;
    sz = used_count();
    if (sz >= lim || sz * thr >= m_pend) return;
    tgt = m_pend / thr;
    if (tgt > lim) tgt = lim;
    if (tgt < 1) tgt = 1;
    while (sz < tgt) begin
      if (!spawn_lowest()) return;
      sz++;
    end
  endfunction

  function automatic void queue_request();
    void'(put_res(ACT_QUEUED, 0));
    drain_pending();
    grow_pool();
  endfunction

  // enqueue variant that also bumps the pending count
  function automatic void enqueue_request();
    if (m_pend < 16'hFFFF) m_pend++;
    queue_request();
  endfunction

  function automatic void predict_event(input logic [2:0] op, input logic [3:0] wk);
    int w;
    step_res.delete();
    w = wk;
    case (op)
      OP_REQUEST: begin
        if (used_count() == 0) begin
          void'(spawn_lowest());
          enqueue_request();
        end else begin
          w = least_loaded();
          if (w >= 0) void'(give_to(w));
          else enqueue_request();
        end
      end
      OP_FINISH: begin
        if (m_used[w]) begin
          if (m_load[w] > 0) m_load[w]--;
          m_idle[w] = '0;
        end
        drain_pending();
      end
      OP_READY: begin
        if (m_used[w]) begin
          m_act[w] = 1;
          m_idle[w] = '0;
        end
        drain_pending();
      end
      OP_DIED: begin
        wipe_slot(w);
        grow_pool();
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (m_used[i] && m_act[i] && m_idle[i] < 16'hFFFF) m_idle[i]++;
        for (int i = 0; i < SLOTS; i++)
          if (m_used[i] && m_act[i] && m_load[i] == 0 && m_idle[i] > m_ilim) begin
            if (!put_res(ACT_DESPAWN, i)) break;
            wipe_slot(i);
          end
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.we <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(negedge clk);
    cfg_ch.we <= 1'b0;
    case (idx)
      REG_CONCURRENCY: m_conc = val[7:0];
      REG_POOL_CAP:    m_plim = val[4:0];
      REG_GROW_STEP:   m_gthr = val[9:0];
      REG_IDLE_LIMIT:  m_ilim = val;
      default: ;
    endcase
  endtask

  // send one event and queue its predicted results
  task automatic send_event(input logic [2:0] op, input logic [3:0] wk,
                            output int n_res, output disp_res_t first);
    while ($urandom_range(99) < send_idle_pct) begin
      ev_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.op <= op;
    ev_ch.worker <= wk;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    predict_event(op, wk);
    n_res = step_res.size();
    first = n_res > 0 ? step_res[0] : '0;
    foreach (step_res[i]) expected_results.push_back(step_res[i]);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    ev_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    disp_res_t want;
    cycles <= cycles + 1;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result action %0d slot %0d",
                         res_ch.action, res_ch.slot));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (res_ch.action !== want.action)
          report($sformatf("action got %0d want %0d", res_ch.action, want.action));
        if (res_ch.slot !== want.slot)
          report($sformatf("slot got %0d want %0d", res_ch.slot, want.slot));
        if (res_ch.last !== want.last)
          report($sformatf("last got %0d want %0d", res_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("least_loaded_worker_dispatcher_unit test failed");
      $finish;
    end
  end

  // directed rows: first expected result typed in where obvious
  function automatic stim_row_t row(input op_t op, input int wk, input int n,
                                    input action_t a, input int s, input bit l);
    stim_row_t r;
    r.op = op; r.worker = wk[3:0]; r.n_exp = n;
    r.first_exp.action = a; r.first_exp.slot = s[3:0]; r.first_exp.last = l;
    return r;
  endfunction

  stim_row_t directed [$];

  task automatic random_phase(input int count, input int sidle, input int rstall);
    int n, pick;
    disp_res_t f;
    logic [2:0] op;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_REQUEST;
      else if (pick < 60) op = OP_FINISH;
      else if (pick < 78) op = OP_READY;
      else if (pick < 85) op = OP_DIED;
      else if (pick < 97) op = OP_TICK;
      else op = 3'($urandom_range(7, 5));
      send_event(op, (pick % 3 == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5)),
                 n, f);
    end
  endtask

  initial begin
    int n;
    disp_res_t f;
    ev_ch.valid = 1'b0;
    ev_ch.op = '0;
    ev_ch.worker = '0;
    res_ch.ready = 1'b0;
    cfg_ch.we = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    m_conc = CONCURRENCY_RST;
    m_plim = POOL_CAP_RST;
    m_gthr = GROW_STEP_RST;
    m_ilim = IDLE_LIMIT_RST;
    for (int i = 0; i < SLOTS; i++) wipe_slot(i);
    m_pend = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset defaults
    directed.push_back(row(OP_FINISH, 3, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_TICK, 0, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_REQUEST, 0, 2, ACT_SPAWN, 0, 0));
    directed.push_back(row(OP_READY, 9, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_READY, 0, 1, ACT_ASSIGN, 0, 1));
    directed.push_back(row(OP_REQUEST, 0, 1, ACT_ASSIGN, 0, 1));
    directed.push_back(row(OP_FINISH, 0, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_FINISH, 15, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_READY, 15, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_DIED, 15, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(op_t'(3'd5), 7, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(op_t'(3'd7), 15, 0, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_TICK, 0, -1, ACT_ASSIGN, 0, 0));
    directed.push_back(row(OP_DIED, 0, 0, ACT_ASSIGN, 0, 0));
    recv_stall_pct = 0;
    foreach (directed[i]) begin
      send_event(directed[i].op, directed[i].worker, n, f);
      if (directed[i].n_exp >= 0 && n != directed[i].n_exp)
        report($sformatf("row %0d result count %0d want %0d", i, n, directed[i].n_exp));
      if (directed[i].n_exp > 0 && f != directed[i].first_exp)
        report($sformatf("row %0d first result differs", i));
    end
    wait_quiet();

    // zero concurrency: requests pile up and the pool grows with the pending count
    write_reg(REG_CONCURRENCY, 16'd0);
    write_reg(REG_GROW_STEP, 16'd0);
    write_reg(REG_POOL_CAP, 16'd31);
    write_reg(REG_IDLE_LIMIT, 16'd0);
    for (int k = 0; k < 6; k++) send_event(OP_REQUEST, 0, n, f);
    for (int k = 0; k < 4; k++) send_event(OP_READY, k, n, f);
    send_event(OP_TICK, 0, n, f);
    wait_quiet();
    write_reg(REG_CONCURRENCY, 16'd255);
    send_event(OP_READY, 1, n, f);
    send_event(OP_READY, 4, n, f);
    wait_quiet();

    // random phases across settings
    write_reg(REG_CONCURRENCY, 16'd2);
    write_reg(REG_POOL_CAP, 16'd4);
    write_reg(REG_GROW_STEP, 16'd1);
    write_reg(REG_IDLE_LIMIT, 16'd2);
    random_phase(35, 0, 0);
    wait_quiet();
    write_reg(REG_CONCURRENCY, 16'd1);
    write_reg(REG_POOL_CAP, 16'd16);
    write_reg(REG_GROW_STEP, 16'd1023);
    write_reg(REG_IDLE_LIMIT, 16'd65535);
    random_phase(35, 55, 0);
    wait_quiet();
    write_reg(REG_CONCURRENCY, 16'd3);
    write_reg(REG_POOL_CAP, 16'd1);
    write_reg(REG_GROW_STEP, 16'd2);
    write_reg(REG_IDLE_LIMIT, 16'd1);
    random_phase(35, 0, 55);
    wait_quiet();

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 0, 0);
    join
    wait_quiet();
    write_reg(REG_CONCURRENCY, 16'd4);
    write_reg(REG_POOL_CAP, 16'd8);
    write_reg(REG_GROW_STEP, 16'd3);
    random_phase(35, 12, 12);
    wait_quiet();

    if (errors == 0) begin
      $display("least_loaded_worker_dispatcher_unit test passed");
    end else begin
      $display("least_loaded_worker_dispatcher_unit test failed");
    end
    $finish;
  end
endmodule
